FILE: rtl/core/larger_than_life_ca_step_assert.svh
// Assertion macros used by the back end of the Larger-than-Life step.
`ifndef LARGER_THAN_LIFE_CA_STEP_ASSERT_SVH
`define LARGER_THAN_LIFE_CA_STEP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define LTL_ASSERT_IMPLY(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define LTL_ASSERT_NEXT(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LTL_ASSERT_IMPLY(name, clock, reset, ante, cons, msg)
`define LTL_ASSERT_NEXT(name, clock, reset, ante, cons, msg)
`endif
`endif

FILE: rtl/core/ltl_pkg.sv
// Package with the constants, word types and register codes of the Larger-than-Life step.
package ltl_pkg;

  // Neighborhood and line buffer geometry.
  localparam int RADIUS_CELLS  = 2;
  localparam int MAX_ROW_CELLS = 1024;
  localparam int SPAN          = 2 * RADIUS_CELLS;
  localparam int SIDE          = 2 * RADIUS_CELLS + 1;

  // Field and counter widths.
  localparam int COL_W    = $clog2(MAX_ROW_CELLS);
  localparam int W_W      = COL_W + 1;
  localparam int ROW_W    = 16;
  localparam int WIDTH_W  = 11;
  localparam int SLOT_W   = $clog2(SPAN);
  localparam int CSUM_W   = 6;
  localparam int CNT_W    = 10;

  // Configuration port.
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDED_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDED_HEIGHT = 3'd5;

  // Decoupling queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input word.
  typedef struct packed {
    logic cell_alive;
    logic frame_start;
  } cell_word_t;

  // Result word.
  typedef struct packed {
    logic             next_alive;
    logic [CNT_W-1:0] neighbor_count;
    logic             frame_last;
  } result_word_t;

  // Grid geometry registers.
  typedef struct packed {
    logic [WIDTH_W-1:0] padded_width;
    logic [ROW_W-1:0]   padded_height;
  } geometry_t;

  // Survival and birth ranges.
  typedef struct packed {
    logic [CNT_W-1:0] survive_min;
    logic [CNT_W-1:0] survive_max;
    logic [CNT_W-1:0] birth_min;
    logic [CNT_W-1:0] birth_max;
  } rule_t;

  // One classified cell, as the front hands it to the back.
  typedef struct packed {
    logic              alive;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  ccol;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] cslot;
    logic              r_zero;
    logic              r_ge_span;
    logic              c_zero;
    logic              c_ge_side;
    logic              emit;
    logic              last;
  } item_t;

endpackage

FILE: rtl/core/ltl_front.sv
// Front end: tracks the raster position of arriving cells and classifies each one.
module ltl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  ltl_pkg::cell_word_t cell_data,
  input  ltl_pkg::geometry_t geometry,
  output ltl_pkg::item_t     item
);
  import ltl_pkg::*;

  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [SLOT_W-1:0] slot, slot_next;

  logic [W_W-1:0]    eff_w;
  logic [ROW_W-1:0]  eff_h;
  logic [COL_W-1:0]  entry_col, cur_col;
  logic [ROW_W-1:0]  entry_row, wrap_row, cur_row, row_inc;
  logic [SLOT_W-1:0] entry_slot, wrap_slot, cur_slot, slot_inc;
  logic [W_W-1:0]    col_inc;

  // Effective geometry: width at least one and clamped to the line buffer, height at least one.
  always_comb begin
    if (geometry.padded_width == '0) begin
      eff_w = W_W'(1);
    end else if (32'(geometry.padded_width) > 32'(MAX_ROW_CELLS)) begin
      eff_w = W_W'(MAX_ROW_CELLS);
    end else begin
      eff_w = W_W'(geometry.padded_width);
    end
    eff_h = (geometry.padded_height == '0) ? ROW_W'(1) : geometry.padded_height;
  end

  // Position of this cell, after a frame start and after wrapping a stale position.
  always_comb begin
    entry_col  = cell_data.frame_start ? '0 : col;
    entry_row  = cell_data.frame_start ? '0 : row;
    entry_slot = cell_data.frame_start ? '0 : slot;
    if ({1'b0, entry_col} >= eff_w) begin
      cur_col   = '0;
      wrap_row  = entry_row + ROW_W'(1);
      wrap_slot = (entry_slot == SLOT_W'(SPAN - 1)) ? '0 : entry_slot + SLOT_W'(1);
    end else begin
      cur_col   = entry_col;
      wrap_row  = entry_row;
      wrap_slot = entry_slot;
    end
    if (wrap_row >= eff_h) begin
      cur_row  = '0;
      cur_slot = '0;
    end else begin
      cur_row  = wrap_row;
      cur_slot = wrap_slot;
    end
  end

  // Classification handed to the back end.
  always_comb begin
    item.alive     = cell_data.cell_alive;
    item.col       = cur_col;
    item.ccol      = cur_col - COL_W'(RADIUS_CELLS);
    item.slot      = cur_slot;
    item.cslot     = (cur_slot >= SLOT_W'(RADIUS_CELLS)) ?
                     cur_slot - SLOT_W'(RADIUS_CELLS) : cur_slot + SLOT_W'(RADIUS_CELLS);
    item.r_zero    = (cur_row == '0);
    item.r_ge_span = (32'(cur_row) >= 32'(SPAN));
    item.c_zero    = (cur_col == '0);
    item.c_ge_side = (32'(cur_col) >= 32'(SIDE));
    item.emit      = (32'(cur_row) >= 32'(SPAN)) && (32'(cur_col) >= 32'(SPAN));
    item.last      = (cur_row == eff_h - ROW_W'(1)) && ({1'b0, cur_col} == eff_w - W_W'(1));
  end

  // Position of the following cell.
  always_comb begin
    col_inc  = {1'b0, cur_col} + W_W'(1);
    row_inc  = cur_row + ROW_W'(1);
    slot_inc = (cur_slot == SLOT_W'(SPAN - 1)) ? '0 : cur_slot + SLOT_W'(1);
    if (col_inc >= eff_w) begin
      col_next = '0;
      if (row_inc >= eff_h) begin
        row_next  = '0;
        slot_next = '0;
      end else begin
        row_next  = row_inc;
        slot_next = slot_inc;
      end
    end else begin
      col_next  = col_inc[COL_W-1:0];
      row_next  = cur_row;
      slot_next = cur_slot;
    end
  end

  // Position registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (take) begin
      col  <= col_next;
      row  <= row_next;
      slot <= slot_next;
    end
  end

endmodule

FILE: rtl/core/ltl_queue.sv
// Short queue of classified cells between the front and the back.
module ltl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ltl_pkg::item_t push_item,
  input  logic           pop,
  output ltl_pkg::item_t head,
  output logic           head_valid,
  output logic           full
);
  import ltl_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == QCNT_W'(QUEUE_DEPTH));

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/ltl_back.sv
// Back end: line buffer, column sums, window sum and the survival and birth rule.
`include "larger_than_life_ca_step_assert.svh"
module ltl_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ltl_pkg::item_t        head,
  input  logic                  head_valid,
  output logic                  pop,
  input  ltl_pkg::rule_t        rule,
  output logic                  clearing,
  output logic                  result_valid,
  input  logic                  result_stall,
  output ltl_pkg::result_word_t result_data
);
  import ltl_pkg::*;

  // Line buffer rows (one bit per ring slot) and column sums, one word per column.
  logic [SPAN-1:0]   row_mem [MAX_ROW_CELLS];
  logic [CSUM_W-1:0] sum_mem [MAX_ROW_CELLS];

  logic              clr_busy;
  logic [COL_W-1:0]  clr_addr;

  logic              b_valid;
  item_t             b;
  logic [SPAN-1:0]   rd_row_a, rd_row_c;
  logic [CSUM_W-1:0] rd_sum;

  logic              fw_valid;
  logic [COL_W-1:0]  fw_col;
  logic [SLOT_W-1:0] fw_slot;
  logic              fw_bit;
  logic [CSUM_W-1:0] fw_sum;

  logic [CNT_W-1:0]  win;
  logic [CSUM_W-1:0] shift [SIDE];

  logic              out_valid;
  result_word_t      out_word;

  logic              adv;
  logic              fw_hit;
  logic [CSUM_W-1:0] prev_sum, full, sum_next, col_old;
  logic              old_bit, centre;
  logic [CNT_W-1:0]  win_prev, win_next, count;
  logic              next_state;

  assign clearing     = clr_busy;
  assign result_valid = out_valid;
  assign result_data  = out_word;

  // The work stage moves when its cell needs no output slot or the slot frees up.
  assign adv = !b_valid || !b.emit || !out_valid || !result_stall;
  assign pop = head_valid && adv && !clr_busy;

  // Column sum and window sum for the cell in the work stage, with forwarding of
  // the write that left this stage in the same cycle as the read was issued.
  always_comb begin
    fw_hit   = fw_valid && (fw_col == b.col);
    prev_sum = b.r_zero ? '0 : (fw_hit ? fw_sum : rd_sum);
    if (!b.r_ge_span) begin
      old_bit = 1'b0;
    end else if (fw_hit && (fw_slot == b.slot)) begin
      old_bit = fw_bit;
    end else begin
      old_bit = rd_row_a[b.slot];
    end
    if (fw_valid && (fw_col == b.ccol) && (fw_slot == b.cslot)) begin
      centre = fw_bit;
    end else begin
      centre = rd_row_c[b.cslot];
    end
    full     = prev_sum + CSUM_W'(b.alive);
    sum_next = full - CSUM_W'(old_bit);
    win_prev = b.c_zero ? '0 : win;
    col_old  = b.c_ge_side ? shift[SIDE-1] : '0;
    win_next = win_prev + CNT_W'(full) - CNT_W'(col_old);
    count    = win_next - CNT_W'(centre);
  end

  // Survival and birth rule.
  always_comb begin
    if (centre) begin
      next_state = (count >= rule.survive_min) && (count <= rule.survive_max);
    end else begin
      next_state = (count >= rule.birth_min) && (count <= rule.birth_max);
    end
  end

  // Clearing pass over the memories after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == COL_W'(MAX_ROW_CELLS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      row_mem[clr_addr] <= '0;
      sum_mem[clr_addr] <= '0;
    end else if (b_valid && adv) begin
      row_mem[b.col][b.slot] <= b.alive;
      sum_mem[b.col]         <= sum_next;
    end
    if (pop) begin
      rd_row_a <= row_mem[head.col];
      rd_row_c <= row_mem[head.ccol];
      rd_sum   <= sum_mem[head.col];
    end
  end

  // Work stage control and the record of the latest memory write.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      if (adv) begin
        b_valid <= pop;
      end
      if (b_valid && adv) begin
        fw_valid <= 1'b1;
      end
    end
  end

  // Work stage payload, forwarding record, window sum and column sum history.
  always_ff @(posedge clk) begin
    if (adv) begin
      b <= head;
    end
    if (b_valid && adv) begin
      fw_col   <= b.col;
      fw_slot  <= b.slot;
      fw_bit   <= b.alive;
      fw_sum   <= sum_next;
      win      <= win_next;
      shift[0] <= full;
      for (int i = 1; i < SIDE; i++) begin
        shift[i] <= shift[i-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_valid && adv && b.emit) begin
      out_valid <= 1'b1;
    end else if (!result_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && adv && b.emit) begin
      out_word.next_alive     <= next_state;
      out_word.neighbor_count <= count;
      out_word.frame_last     <= b.last;
    end
  end

  `LTL_ASSERT_IMPLY(a_clear_idle, clk, rst, clr_busy, !b_valid && !pop, "cell in flight during clearing pass")
  `LTL_ASSERT_NEXT(a_result_loaded, clk, rst, b_valid && adv && b.emit, out_valid, "emitting cell left no result")
  `LTL_ASSERT_NEXT(a_forward_record, clk, rst, b_valid && adv, fw_valid && (fw_col == $past(b.col)) && (fw_sum == $past(sum_next)), "forwarding record does not match last write")

endmodule

FILE: rtl/core/larger_than_life_ca_step.sv
// Larger-than-Life step: one cell word per cycle in while cell_stall is low, one result
// word per inner cell out. A result word passes through the queue, the work stage and
// the output register before it is valid. The input rate is set by the single
// read-modify-write of the column sum memory per cell in the back end.
// Reset: rst clears the configuration to its defaults and starts a clearing pass over all
// 1024 entries of the line buffer and column sums; cell_stall stays high until it ends.
module larger_than_life_ca_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cell_valid,
  output logic                                cell_stall,
  input  ltl_pkg::cell_word_t                 cell_data,
  output logic                                result_valid,
  input  logic                                result_stall,
  output ltl_pkg::result_word_t               result_data,
  input  logic                                cfg_write,
  input  logic [ltl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ltl_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ltl_pkg::*;

  rule_t     rule;
  geometry_t geometry;

  logic  take;
  item_t front_item;
  item_t head;
  logic  head_valid;
  logic  pop;
  logic  q_full;
  logic  clearing;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rule.survive_min       <= CNT_W'(2);
      rule.survive_max       <= CNT_W'(3);
      rule.birth_min         <= CNT_W'(3);
      rule.birth_max         <= CNT_W'(3);
      geometry.padded_width  <= WIDTH_W'(1024);
      geometry.padded_height <= ROW_W'(1024);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SURVIVE_MIN:   rule.survive_min       <= cfg_data[CNT_W-1:0];
        CFG_SURVIVE_MAX:   rule.survive_max       <= cfg_data[CNT_W-1:0];
        CFG_BIRTH_MIN:     rule.birth_min         <= cfg_data[CNT_W-1:0];
        CFG_BIRTH_MAX:     rule.birth_max         <= cfg_data[CNT_W-1:0];
        CFG_PADDED_WIDTH:  geometry.padded_width  <= cfg_data[WIDTH_W-1:0];
        CFG_PADDED_HEIGHT: geometry.padded_height <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // A cell word is taken while the queue has room and no clearing pass runs.
  assign cell_stall = q_full || clearing;
  assign take       = cell_valid && !cell_stall;

  ltl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .cell_data (cell_data),
    .geometry  (geometry),
    .item      (front_item)
  );

  ltl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_item  (front_item),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  ltl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .rule         (rule),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

FILE: test/larger_than_life_ca_step_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Larger-than-Life step: random grids, rules, gaps and stalls.
module larger_than_life_ca_step_tb;
  import ltl_pkg::*;

  localparam int RUN_LIMIT   = 400000;
  localparam int IDLE_PCT    = 38;
  localparam int HOLD_CYCLES = 250;
  localparam int REPORT_CAP  = 200;
  localparam int STORE_BITS  = SPAN * MAX_ROW_CELLS;

  // Effective row length: a zero width is one column, a wide one is clamped to the buffer.
  function automatic int unsigned eff_width(int unsigned w);
    if (w == 0) return 1;
    if (w > MAX_ROW_CELLS) return MAX_ROW_CELLS;
    return w;
  endfunction

  // Predicts the next generation from the accepted cell words and checks each result word.
  class life_scoreboard;
    logic [CNT_W-1:0]   survive_lo, survive_hi, birth_lo, birth_hi;
    logic [WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;
    bit                 line_bits [STORE_BITS];
    logic [CSUM_W-1:0]  column_totals [MAX_ROW_CELLS];
    logic [CSUM_W-1:0]  recent_totals [SIDE];
    logic [CNT_W-1:0]   box_total;
    int unsigned        col_pos, row_pos;
    result_word_t       expected_q [$];
    int unsigned        failures, results_seen;

    function new();
      survive_lo = 10'd2;
      survive_hi = 10'd3;
      birth_lo   = 10'd3;
      birth_hi   = 10'd3;
      width_reg  = 11'd1024;
      height_reg = 16'd1024;
      foreach (line_bits[i]) line_bits[i] = 1'b0;
      foreach (column_totals[i]) column_totals[i] = '0;
      foreach (recent_totals[i]) recent_totals[i] = '0;
      box_total    = '0;
      col_pos      = 0;
      row_pos      = 0;
      failures     = 0;
      results_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_SURVIVE_MIN:   survive_lo = value[CNT_W-1:0];
        CFG_SURVIVE_MAX:   survive_hi = value[CNT_W-1:0];
        CFG_BIRTH_MIN:     birth_lo   = value[CNT_W-1:0];
        CFG_BIRTH_MAX:     birth_hi   = value[CNT_W-1:0];
        CFG_PADDED_WIDTH:  width_reg  = value[WIDTH_W-1:0];
        CFG_PADDED_HEIGHT: height_reg = value[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_cell(cell_word_t word);
      int unsigned       eff_w, eff_h, r, c, slot, rs, centre_slot;
      logic [CSUM_W-1:0] prior, full, leaving;
      logic [CNT_W-1:0]  prior_box, leaving_col, count;
      bit                centre;
      result_word_t      res;
      eff_w = eff_width(width_reg);
      eff_h = (height_reg == 0) ? 1 : height_reg;

      // Position of this cell, wrapping past a shrunken row or grid.
      if (word.frame_start) begin
        col_pos = 0;
        row_pos = 0;
      end
      if (col_pos >= eff_w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= eff_h) row_pos = 0;
      r = row_pos;
      c = col_pos;

      // Vertical sum over rows r-2R .. r; nothing leaves before row 2R of this grid.
      slot = (r % SPAN) * MAX_ROW_CELLS + c;
      leaving = '0;
      if (r >= SPAN) leaving[0] = line_bits[slot];
      prior = (r == 0) ? '0 : column_totals[c];
      full = prior + word.cell_alive;
      column_totals[c] = full - leaving;
      line_bits[slot] = word.cell_alive;

      // Running box sum along the row over columns c-2R .. c.
      rs = c % SIDE;
      leaving_col = (c >= SIDE) ? recent_totals[rs] : '0;
      prior_box = (c == 0) ? '0 : box_total;
      box_total = prior_box + full - leaving_col;
      recent_totals[rs] = full;

      // A complete window yields the new state of its center cell.
      if (r >= SPAN && c >= SPAN) begin
        centre_slot = ((r - RADIUS_CELLS) % SPAN) * MAX_ROW_CELLS + c - RADIUS_CELLS;
        centre = line_bits[centre_slot];
        count = box_total - centre;
        if (centre) res.next_alive = (count >= survive_lo) && (count <= survive_hi);
        else res.next_alive = (count >= birth_lo) && (count <= birth_hi);
        res.neighbor_count = count;
        res.frame_last = (r == eff_h - 1) && (c == eff_w - 1);
        expected_q.push_back(res);
      end

      col_pos = c + 1;
      if (col_pos >= eff_w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= eff_h) row_pos = 0;
      end
    endfunction

    function void note_mismatch(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      failures++;
      if (failures <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_CAP)
          $display("%0t: result word with none expected, got next_alive %0b count %0d last %0b",
                   $time, got.next_alive, got.neighbor_count, got.frame_last);
        return;
      end
      want = expected_q.pop_front();
      if (got.next_alive !== want.next_alive)
        note_mismatch("next_alive", want.next_alive, got.next_alive);
      if (got.neighbor_count !== want.neighbor_count)
        note_mismatch("neighbor_count", want.neighbor_count, got.neighbor_count);
      if (got.frame_last !== want.frame_last)
        note_mismatch("frame_last", want.frame_last, got.frame_last);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void flag_leftovers();
      if (expected_q.size() != 0) begin
        failures += expected_q.size();
        $display("%0t: %0d expected result words never arrived", $time, expected_q.size());
      end
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cell_valid   = 1'b0;
  cell_word_t            cell_data    = '0;
  logic                  result_stall = 1'b0;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  cell_stall;
  logic                  result_valid;
  result_word_t          result_data;

  life_scoreboard book = new();
  bit             no_gaps    = 1'b0;
  int unsigned    hold_left  = 0;
  int unsigned    holds_done = 0;

  larger_than_life_ca_step dut (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_data    (cell_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: check each accepted word, then choose the next stall, with two long hold-offs.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) book.check_result(result_data);
    if (hold_left == 0 && ((holds_done == 0 && book.results_seen >= 60) ||
                           (holds_done == 1 && book.results_seen >= 150))) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Run limit.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("larger_than_life_ca_step test failed");
    $finish;
  end

  // Offer one cell word, with random idle cycles ahead of it, and hold it until accepted.
  task automatic send_word(cell_word_t word);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      cell_valid <= 1'b0;
      @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_data  <= word;
    @(posedge clk);
    while (cell_stall) @(posedge clk);
    book.note_cell(word);
  endtask

  // Register write; the caller lowers the write enable after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    book.set_register(idx, value[CFG_DATA_W-1:0]);
  endtask

  task automatic program_step(int unsigned s_lo, int unsigned s_hi, int unsigned b_lo,
                              int unsigned b_hi, int unsigned w, int unsigned h);
    write_reg(CFG_SURVIVE_MIN, s_lo);
    write_reg(CFG_SURVIVE_MAX, s_hi);
    write_reg(CFG_BIRTH_MIN, b_lo);
    write_reg(CFG_BIRTH_MAX, b_hi);
    write_reg(CFG_PADDED_WIDTH, w);
    write_reg(CFG_PADDED_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  // Wait for every expected word, then let cells that give no result leave the pipeline.
  task automatic settle_block();
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Rule bounds: mostly within the reachable counts, sometimes at the register extremes.
  function automatic int unsigned pick_count();
    case ($urandom_range(9))
      0: return 0;
      1: return 1023;
      2: return $urandom_range(1023);
      default: return $urandom_range(24);
    endcase
  endfunction

  // One phase: new rules and geometry, then whole grids of random cells. Some grids are
  // noisy, with stray or missing grid starts. A phase that is not fresh keeps the position.
  // Very large grids are cut short to the start of their first rows.
  task automatic run_phase(input bit fresh, input int unsigned w, input int unsigned h,
                           input int unsigned grids, output int unsigned sent);
    int unsigned eff_w, eff_h, per_grid, total, density, g;
    bit          noisy;
    cell_word_t  word;
    eff_w = eff_width(w);
    eff_h = (h == 0) ? 1 : h;
    per_grid = eff_w * eff_h;
    total = grids * per_grid;
    if (total > 600) total = (eff_w > 16) ? 64 : eff_w * 8;
    density = 50;
    noisy = 1'b0;
    program_step(pick_count(), pick_count(), pick_count(), pick_count(), w, h);
    for (int unsigned i = 0; i < total; i++) begin
      g = i % per_grid;
      if (g == 0) begin
        density = $urandom_range(90, 10);
        noisy = ($urandom_range(99) < 15);
      end
      word.cell_alive = ($urandom_range(99) < density);
      if (i == 0) word.frame_start = fresh;
      else if (!noisy) word.frame_start = (g == 0);
      else if (g == 0) word.frame_start = $urandom_range(1);
      else word.frame_start = ($urandom_range(99) < 4);
      send_word(word);
    end
    cell_valid <= 1'b0;
    settle_block();
    sent = total;
  endtask

  initial begin : stimulus
    int unsigned k, spread_items, sent, cur_w, w, h, grids, drain;
    bit          fresh;
    cell_word_t  word;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the start of a 1024-wide row gives no result.
    for (int i = 0; i < 4; i++) begin
      word.cell_alive  = i[0];
      word.frame_start = (i == 0);
      send_word(word);
    end
    cell_valid <= 1'b0;
    settle_block();

    // Smallest complete grid: all live around a dead center, born at the full count.
    program_step(0, 1023, 24, 24, 5, 5);
    for (int i = 0; i < 25; i++) begin
      word.cell_alive  = (i != 12);
      word.frame_start = (i == 0);
      send_word(word);
    end
    cell_valid <= 1'b0;
    settle_block();

    // Geometry extremes first, then random phases until about 800 cell words have gone in.
    k = 0;
    spread_items = 0;
    cur_w = 5;
    while (k < 7 || spread_items < 800) begin
      fresh = 1'b1;
      grids = $urandom_range(3, 1);
      w = $urandom_range(14, 3);
      h = $urandom_range(12, 3);
      no_gaps = 1'b0;
      case (k)
        0: begin
          // Zero width reads as a single column.
          w = 0;
          h = 7;
          grids = 3;
        end
        1: h = 0;
        2: begin
          // Too few rows for any window.
          w = 7;
          h = 3;
        end
        3: begin
          w = 12;
          h = 12;
          grids = 2;
          no_gaps = 1'b1;
        end
        4: begin
          // Width beyond the line buffer is clamped.
          w = 2047;
          h = 5;
          grids = 1;
        end
        5: begin
          w = MAX_ROW_CELLS;
          h = 6;
          grids = 1;
        end
        6: begin
          // Tallest grid; only its top rows are streamed.
          w = 5;
          h = 65535;
        end
        default: begin
          // Keep going inside the current grid with a row that is no wider.
          if (cur_w >= 3 && $urandom_range(3) == 0) begin
            fresh = 1'b0;
            w = $urandom_range((cur_w < 14) ? cur_w : 14, 3);
          end
        end
      endcase
      run_phase(fresh, w, h, grids, sent);
      spread_items += sent;
      cur_w = eff_width(w);
      k++;
    end
    no_gaps = 1'b0;

    drain = 0;
    while (book.pending() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    book.flag_leftovers();
    if (book.failures == 0) begin
      $display("larger_than_life_ca_step test passed");
    end else begin
      $display("larger_than_life_ca_step test failed");
    end
    $finish;
  end

endmodule
